@@ hdl/flt_pkg.sv @@
// Shared types and constants for the flow liveness and sequence tracker.
// Holds the per-flow record layout, the result layout and register indexes.
// No dependencies.
package flt_pkg;

  // Field widths
  localparam int unsigned FLOW_W   = 6;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned PERIOD_W = 22;
  localparam int unsigned MULT_W   = 8;
  localparam int unsigned WIN_W    = 22;
  localparam int unsigned TMO_W    = PERIOD_W + MULT_W;

  // Default table depth
  localparam int unsigned NUM_FLOWS_DEF = 64;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 192;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

  // Register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1000);
  localparam logic [MULT_W-1:0]   MULT_RST   = MULT_W'(3);
  localparam logic [WIN_W-1:0]    WINDOW_RST = WIN_W'(60000);

  // Result kinds and input actions
  localparam logic KIND_PACKET  = 1'b0;
  localparam logic KIND_OFFLINE = 1'b1;
  localparam logic ACT_PACKET   = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  // One flow record as stored in the table memory
  typedef struct packed {
    logic [TIME_W-1:0] last_seen;
    logic [TIME_W-1:0] off_since;
    logic [TIME_W-1:0] win_num;
    logic [SEQ_W-1:0]  min_seq;
    logic [SEQ_W-1:0]  max_seq;
    logic [CNT_W-1:0]  recv;
    logic [CNT_W-1:0]  reord;
    logic              restarted;
  } rec_t;

  // Result payload, flow_index in the lowest bits
  typedef struct packed {
    logic              restarted;
    logic [CNT_W-1:0]  reord;
    logic [CNT_W-1:0]  recv;
    logic [SEQ_W-1:0]  max_seq;
    logic [SEQ_W-1:0]  min_seq;
    logic              seq_tracked;
    logic [TIME_W-1:0] offline_ms;
    logic              came_online;
    logic              new_flow;
    logic [FLOW_W-1:0] flow_index;
  } res_data_t;

  typedef struct packed {
    logic      kind;
    logic      last;
    res_data_t data;
  } res_t;

endpackage

@@ hdl/flt_rec_mem.sv @@
// Flow record table: one write port, one read port, registered read data.
// Depends on flt_pkg for the record type.
module flt_rec_mem #(
  parameter int unsigned DEPTH  = flt_pkg::NUM_FLOWS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  flt_pkg::rec_t      wdata_i,
  input  logic               re_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output flt_pkg::rec_t      rdata_o
);
  import flt_pkg::*;

  rec_t mem_q [DEPTH];
  rec_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/flt_win_div.sv @@
// Restoring divider, one quotient bit per cycle, for the window number.
// Depends on flt_pkg for the time and window widths.
module flt_win_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [flt_pkg::TIME_W-1:0] dividend_i,
  input  logic [flt_pkg::WIN_W-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [flt_pkg::TIME_W-1:0] quot_o
);
  import flt_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(TIME_W + 1);

  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [TIME_W-1:0]   q_q, q_d;
  logic [WIN_W:0]      rem_q, rem_d;
  logic [WIN_W-1:0]    dvs_q, dvs_d;
  logic [WIN_W:0]      rem_sh;

  // one shift-subtract step per cycle
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    q_d    = q_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q[WIN_W-1:0], q_q[TIME_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(TIME_W);
      q_d    = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        q_d   = {q_q[TIME_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        q_d   = {q_q[TIME_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;

endmodule

@@ hdl/flow_liveness_and_sequence_tracker.sv @@
// Per-flow liveness and sequence tracker. A packet request costs a table read, an optional
// window division, done only when it carries a sequence number and window_ms is nonzero, and
// a write back. A tick request scans the record table in flow order: an idle flow is skipped,
// an online flow takes one memory read and one evaluate/write, and a closing step flushes any
// held report. A full output register stalls the scan. One request is in work at a time;
// memory accesses to one entry never overlap. No clearing pass after reset.
// Depends on flt_pkg, flt_rec_mem and flt_win_div.
module flow_liveness_and_sequence_tracker #(
  parameter int unsigned NUM_FLOWS = flt_pkg::NUM_FLOWS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [flt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [flt_pkg::PERIOD_W-1:0]      cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // flow_id[5:0], time_ms[53:6], seq_valid[54], seq_num[86:55], zero pad
  input  logic [flt_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // action
  input  logic                              s_axis_tuser_i,
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // flow_index[5:0], new_flow[6], came_online[7], offline_ms[55:8], seq_tracked[56],
  // min_seq_out[88:57], max_seq_out[120:89], received_count[152:121],
  // reorder_count[184:153], session_restarted[185], zero pad
  output logic [flt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // kind
  output logic                              m_axis_tuser_o,
  // last_of_run
  output logic                              m_axis_tlast_o
);
  import flt_pkg::*;

  localparam int unsigned FW = $clog2(NUM_FLOWS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PKT   = 2'd1;
  localparam logic [1:0] S_TRD   = 2'd2;
  localparam logic [1:0] S_TEVAL = 2'd3;

  // config registers
  logic [PERIOD_W-1:0] period_q;
  logic [MULT_W-1:0]   mult_q;
  logic [WIN_W-1:0]    win_ms_q;
  logic [TMO_W-1:0]    timeout_q;

  // control
  logic [1:0]          state_q, state_d;
  logic                tick_end_q, tick_end_d;
  logic [FW-1:0]       idx_q, idx_d;
  logic [TIME_W-1:0]   t_q;
  logic                sv_q;
  logic [SEQ_W-1:0]    seq_q;

  // per-flow flags
  logic [NUM_FLOWS-1:0] valid_q, valid_d, online_q, online_d;
  logic [NUM_FLOWS-1:0] wstart_q, wstart_d, hasseq_q, hasseq_d;

  // output register and pending slot
  logic out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;
  res_t out_q, out_d, pend_q, pend_d;
  logic out_free;

  // input fields
  logic [FLOW_W-1:0] in_flow;
  logic [TIME_W-1:0] in_time;
  logic              in_sv;
  logic [SEQ_W-1:0]  in_seq;
  logic              in_acc, in_range, pkt_go;

  // memory and divider
  logic          mem_we, mem_re;
  logic [FW-1:0] mem_raddr;
  rec_t          mem_wdata, rec;
  logic          div_start, div_busy;
  logic [TIME_W-1:0] quot;

  // packet update terms
  logic              v, on, ws;
  logic [TIME_W-1:0] win, t_diff;
  logic              roll, ns, seq_lt, seq_gt;
  logic [SEQ_W:0]    span, thr;
  logic [SEQ_W-1:0]  fall;
  rec_t              base, nrec;
  res_data_t         pres, tres;
  logic              timed_out;

  assign in_flow  = s_axis_tdata_i[FLOW_W-1:0];
  assign in_time  = s_axis_tdata_i[FLOW_W +: TIME_W];
  assign in_sv    = s_axis_tdata_i[FLOW_W + TIME_W];
  assign in_seq   = s_axis_tdata_i[FLOW_W + TIME_W + 1 +: SEQ_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range = {1'b0, in_flow} < (FLOW_W + 1)'(NUM_FLOWS);
  assign pkt_go   = in_acc && (s_axis_tuser_i == ACT_PACKET) && in_range;
  assign div_start = pkt_go && in_sv && (win_ms_q != '0);
  assign out_free = !out_valid_q || m_axis_tready_i;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PERIOD_RST;
      mult_q    <= MULT_RST;
      win_ms_q  <= WINDOW_RST;
      timeout_q <= TMO_W'(PERIOD_RST) * TMO_W'(MULT_RST);
    end else begin
      timeout_q <= TMO_W'(period_q) * TMO_W'(mult_q);
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_PERIOD: period_q <= cfg_data_i;
          CFG_MULT:   mult_q   <= cfg_data_i[MULT_W-1:0];
          CFG_WINDOW: win_ms_q <= cfg_data_i[WIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  flt_rec_mem #(.DEPTH(NUM_FLOWS), .ADDR_W(FW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rec)
  );

  flt_win_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_time),
    .divisor_i  (win_ms_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // packet record update
  always_comb begin
    v  = valid_q[idx_q];
    on = online_q[idx_q];
    ws = wstart_q[idx_q];
    win  = (win_ms_q != '0) ? quot : '0;
    roll = !ws || (rec.win_num != win);
    base = rec;
    if (roll) begin
      base.win_num   = win;
      base.min_seq   = seq_q;
      base.max_seq   = seq_q;
      base.recv      = '0;
      base.reord     = '0;
      base.restarted = 1'b0;
    end
    // session restart test on the stored window
    span   = {1'b0, rec.max_seq} - {1'b0, rec.min_seq} + (SEQ_W + 1)'(1);
    thr    = (span > (SEQ_W + 1)'(2)) ? (span >> 1) : (SEQ_W + 1)'(1);
    fall   = rec.max_seq - seq_q;
    ns     = !roll && (seq_q < rec.max_seq) && ({1'b0, fall} > thr);
    seq_lt = seq_q < base.max_seq;
    seq_gt = seq_q > base.max_seq;
    nrec = base;
    nrec.last_seen = t_q;
    if (ns) begin
      nrec.min_seq   = seq_q;
      nrec.max_seq   = seq_q;
      nrec.recv      = '0;
      nrec.reord     = '0;
      nrec.restarted = 1'b1;
    end else begin
      if (seq_lt && (base.reord != '1)) nrec.reord = base.reord + 1'b1;
      if (seq_gt) nrec.max_seq = seq_q;
      if (seq_q < base.min_seq) nrec.min_seq = seq_q;
    end
    if (nrec.recv != '1) nrec.recv = nrec.recv + 1'b1;
    if (!sv_q) begin
      nrec = rec;
      nrec.last_seen = t_q;
    end
    // packet result
    pres.flow_index  = FLOW_W'(idx_q);
    pres.new_flow    = !v;
    pres.came_online = !v || !on;
    pres.offline_ms  = (v && !on && (t_q >= rec.off_since)) ? (t_q - rec.off_since) : '0;
    pres.seq_tracked = sv_q;
    if (ws || sv_q) begin
      pres.min_seq   = nrec.min_seq;
      pres.max_seq   = nrec.max_seq;
      pres.recv      = nrec.recv;
      pres.reord     = nrec.reord;
      pres.restarted = nrec.restarted;
    end else begin
      pres.min_seq   = '0;
      pres.max_seq   = '0;
      pres.recv      = '0;
      pres.reord     = '0;
      pres.restarted = 1'b0;
    end
    // tick evaluation
    t_diff    = t_q - rec.last_seen;
    timed_out = (t_q > rec.last_seen) && (t_diff > TIME_W'(timeout_q));
    tres.flow_index  = FLOW_W'(idx_q);
    tres.new_flow    = 1'b0;
    tres.came_online = 1'b0;
    tres.offline_ms  = '0;
    tres.seq_tracked = hasseq_q[idx_q];
    if (ws) begin
      tres.min_seq   = rec.min_seq;
      tres.max_seq   = rec.max_seq;
      tres.recv      = rec.recv;
      tres.reord     = rec.reord;
      tres.restarted = rec.restarted;
    end else begin
      tres.min_seq   = '0;
      tres.max_seq   = '0;
      tres.recv      = '0;
      tres.reord     = '0;
      tres.restarted = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    tick_end_d   = tick_end_q;
    idx_d        = idx_q;
    valid_d      = valid_q;
    online_d     = online_q;
    wstart_d     = wstart_q;
    hasseq_d     = hasseq_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_wdata    = nrec;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (pkt_go) begin
          mem_re    = 1'b1;
          mem_raddr = in_flow[FW-1:0];
          idx_d     = in_flow[FW-1:0];
          state_d   = S_PKT;
        end else if (in_acc && (s_axis_tuser_i == ACT_TICK)) begin
          idx_d      = '0;
          tick_end_d = 1'b0;
          state_d    = S_TRD;
        end
      end
      S_PKT: begin
        if (!div_busy && out_free) begin
          mem_we           = 1'b1;
          valid_d[idx_q]   = 1'b1;
          online_d[idx_q]  = 1'b1;
          hasseq_d[idx_q]  = sv_q;
          wstart_d[idx_q]  = ws || sv_q;
          out_valid_d      = 1'b1;
          out_d.kind       = KIND_PACKET;
          out_d.last       = 1'b1;
          out_d.data       = pres;
          state_d          = S_IDLE;
        end
      end
      S_TRD: begin
        if (tick_end_q) begin
          // flush the held report as the last one
          if (!pend_valid_q) begin
            state_d = S_IDLE;
          end else if (out_free) begin
            out_valid_d  = 1'b1;
            out_d        = pend_q;
            out_d.last   = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = S_IDLE;
          end
        end else if (valid_q[idx_q] && online_q[idx_q]) begin
          mem_re  = 1'b1;
          state_d = S_TEVAL;
        end else begin
          if (idx_q == FW'(NUM_FLOWS - 1)) tick_end_d = 1'b1;
          else idx_d = idx_q + 1'b1;
        end
      end
      S_TEVAL: begin
        if (!timed_out || !pend_valid_q || out_free) begin
          if (timed_out) begin
            mem_we          = 1'b1;
            mem_wdata       = rec;
            mem_wdata.off_since = t_q;
            online_d[idx_q] = 1'b0;
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
            end
            pend_valid_d = 1'b1;
            pend_d.kind  = KIND_OFFLINE;
            pend_d.last  = 1'b0;
            pend_d.data  = tres;
          end
          if (idx_q == FW'(NUM_FLOWS - 1)) tick_end_d = 1'b1;
          else idx_d = idx_q + 1'b1;
          state_d = S_TRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tick_end_q   <= 1'b0;
      idx_q        <= '0;
      valid_q      <= '0;
      online_q     <= '0;
      wstart_q     <= '0;
      hasseq_q     <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      tick_end_q   <= tick_end_d;
      idx_q        <= idx_d;
      valid_q      <= valid_d;
      online_q     <= online_d;
      wstart_q     <= wstart_d;
      hasseq_q     <= hasseq_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // request fields and result payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_q   <= in_time;
      sv_q  <= in_sv;
      seq_q <= in_seq;
    end
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - $bits(res_data_t))'(0), out_q.data};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;

  // no report may be held back between requests
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q) else $error("held report left in idle");

  // divider only runs for a packet waiting on its window number
  a_div_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_PKT)) else $error("divider busy outside packet work");

  // table writes only in the update states, never together with a read
  a_mem_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_PKT || state_q == S_TEVAL) && !mem_re))
    else $error("table write outside update");

endmodule

@@ tb/flow_liveness_and_sequence_tracker_tb.sv @@
// Testbench for the flow liveness and sequence tracker: directed and random packet and
// tick requests, with a scoreboard that predicts every result and checks it in order.
// Depends on flt_pkg and the flow_liveness_and_sequence_tracker RTL.
module flow_liveness_and_sequence_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import flt_pkg::*;

  localparam int unsigned NFLOWS = 64;
  localparam longint unsigned CNT_SAT = 64'hFFFF_FFFF;
  localparam longint unsigned LIMIT_CYCLES = 3_000_000;

  typedef struct packed {
    logic              kind;
    logic              last;
    logic [191:0]      data;
  } tracker_result_t;

  // Per-flow record mirror and expected result queue
  class tracker_scoreboard;
    bit                 seen[NFLOWS];
    bit                 online[NFLOWS];
    longint unsigned    last_t[NFLOWS];
    longint unsigned    off_t[NFLOWS];
    longint unsigned    win_no[NFLOWS];
    bit                 win_on[NFLOWS];
    bit                 has_seq[NFLOWS];
    longint unsigned    mn[NFLOWS];
    longint unsigned    mx[NFLOWS];
    longint unsigned    rcv[NFLOWS];
    longint unsigned    reo[NFLOWS];
    bit                 rst_flag[NFLOWS];
    longint unsigned    period = 1000;
    longint unsigned    mult = 3;
    longint unsigned    win_len = 60000;
    tracker_result_t    pending[$];
    int                 errors;
    int                 checked;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
      case (idx)
        CFG_PERIOD: period = val & 22'h3FFFFF;
        CFG_MULT:   mult = val & 8'hFF;
        CFG_WINDOW: win_len = val & 22'h3FFFFF;
        default: ;
      endcase
    endfunction

    function tracker_result_t build(int f, bit kind, bit nf, bit on, longint unsigned offms);
      tracker_result_t r;
      res_data_t d;
      d = '0;
      d.flow_index = f[5:0];
      d.new_flow = nf;
      d.came_online = on;
      d.offline_ms = offms[47:0];
      d.seq_tracked = has_seq[f];
      if (win_on[f]) begin
        d.min_seq = mn[f][31:0];
        d.max_seq = mx[f][31:0];
        d.recv = rcv[f][31:0];
        d.reord = reo[f][31:0];
        d.restarted = rst_flag[f];
      end
      r.kind = kind;
      r.last = 1'b0;
      r.data = 192'(d);
      return r;
    endfunction

    // Note one accepted request and queue the results it causes
    function void note_request(bit act, logic [87:0] td);
      longint unsigned t, seq, w, tmo, span, thr;
      int f, n;
      bit nf, on;
      longint unsigned offms;
      tracker_result_t r;
      t = 64'(td[53:6]);
      n = 0;
      if (act == ACT_TICK) begin
        tmo = period * mult;
        for (int i = 0; i < NFLOWS; i++) begin
          if (seen[i] && online[i] && t > last_t[i] && t - last_t[i] > tmo) begin
            online[i] = 0;
            off_t[i] = t;
            pending.insert(pending.size(), build(i, KIND_OFFLINE, 0, 0, 0));
            n++;
          end
        end
      end else begin
        f = int'(td[5:0]);
        nf = 0; on = 0; offms = 0;
        if (!seen[f]) begin
          seen[f] = 1; online[f] = 1; nf = 1; on = 1;
        end
        last_t[f] = t;
        if (!online[f]) begin
          online[f] = 1; on = 1;
          offms = (t >= off_t[f]) ? t - off_t[f] : 0;
        end
        if (!td[54]) begin
          has_seq[f] = 0;
        end else begin
          seq = 64'(td[86:55]);
          w = win_len ? t / win_len : 0;
          has_seq[f] = 1;
          if (!win_on[f] || win_no[f] != w) begin
            win_on[f] = 1; win_no[f] = w;
            mn[f] = seq; mx[f] = seq; rcv[f] = 0; reo[f] = 0; rst_flag[f] = 0;
          end
          span = mx[f] - mn[f] + 1;
          thr = span > 2 ? span / 2 : 1;
          if (seq < mx[f] && mx[f] - seq > thr) begin
            mn[f] = seq; mx[f] = seq; rcv[f] = 0; reo[f] = 0; rst_flag[f] = 1;
          end else begin
            if (seq < mx[f] && reo[f] < CNT_SAT) reo[f]++;
            if (seq > mx[f]) mx[f] = seq;
            if (seq < mn[f]) mn[f] = seq;
          end
          if (rcv[f] < CNT_SAT) rcv[f]++;
        end
        pending.insert(pending.size(), build(f, KIND_PACKET, nf, on, offms));
        n = 1;
      end
      if (n > 0) pending[$].last = 1'b1;
    endfunction

    function bit check_result(tracker_result_t got, output string msg);
      tracker_result_t e;
      checked++;
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected result kind=%0b data=%h", got.kind, got.data);
        return 0;
      end
      e = pending.pop_front();
      if (got !== e) begin
        msg = $sformatf("result %0d: got k=%0b l=%0b %h exp k=%0b l=%0b %h",
                        checked, got.kind, got.last, got.data, e.kind, e.last, e.data);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              cfg_valid_i = 0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [21:0]       cfg_data_i = '0;
  logic              s_axis_tvalid_i = 0;
  logic              s_axis_tready_o;
  logic [87:0]       s_axis_tdata_i = '0;
  logic              s_axis_tuser_i = 0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 0;
  logic [191:0]      m_axis_tdata_o;
  logic              m_axis_tuser_o;
  logic              m_axis_tlast_o;

  flow_liveness_and_sequence_tracker u_dut (.*);

  tracker_scoreboard sb = new();
  int               mismatches = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               hold_cycles = 0;
  longint unsigned  cycle_no = 0;
  int               n_packets = 0;
  int               n_ticks = 0;
  longint unsigned  now_ms = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0d: %s", cycle_no, msg);
    mismatches++;
  endtask

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_no);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result sampling at the rising edge
  always @(posedge clk_i) begin
    string msg;
    tracker_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind = m_axis_tuser_o;
      got.last = m_axis_tlast_o;
      got.data = m_axis_tdata_o;
      if (!sb.check_result(got, msg)) report_mismatch(msg);
    end
  end

  // Receiver ready, with a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready_i <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [21:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Offer one request; valid stays high until accepted
  task automatic send_request(bit act, logic [5:0] f, longint unsigned t, bit sv,
                              logic [31:0] seq);
    logic [87:0] td;
    td = '0;
    td[5:0] = f;
    td[53:6] = t[47:0];
    td[54] = sv;
    td[86:55] = seq;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= td;
    s_axis_tuser_i <= act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(act, td);
    if (act == ACT_TICK) n_ticks++; else n_packets++;
    @(negedge clk_i);
    s_axis_tvalid_i <= 0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    // ticks may still be scanning with nothing left to report
    repeat (300) @(posedge clk_i);
  endtask

  // Random request: mostly packets on a small set of flows, with time mostly advancing
  task automatic random_request();
    int r;
    logic [5:0] f;
    logic [31:0] seq;
    r = $urandom_range(99);
    if (r < 4) now_ms = now_ms - $urandom_range(50);
    else if (r < 15) now_ms = now_ms + $urandom_range(20000);
    else now_ms = now_ms + $urandom_range(300);
    if ($urandom_range(99) < 15) begin
      send_request(ACT_TICK, 6'($urandom), now_ms, 1'($urandom), $urandom);
    end else begin
      f = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
      case ($urandom_range(5))
        0: seq = $urandom;
        1: seq = 32'($urandom_range(20));
        2: seq = 32'hFFFF_FFFF - $urandom_range(5);
        default: seq = sb.mx[f][31:0] + 32'($urandom_range(6)) - 32'd3;
      endcase
      send_request(ACT_PACKET, f, now_ms, $urandom_range(9) != 0, seq);
    end
  endtask

  initial begin
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: new flows, field extremes, fall-back, offline and return
    send_request(ACT_TICK, 6'd0, 0, 0, 0);
    send_request(ACT_PACKET, 6'd0, 0, 1, 32'd0);
    send_request(ACT_PACKET, 6'd63, 48'hFFFF_FFFF_FFFF, 1, 32'hFFFF_FFFF);
    send_request(ACT_PACKET, 6'd1, 100, 1, 32'd100);
    send_request(ACT_PACKET, 6'd1, 110, 1, 32'd104);
    send_request(ACT_PACKET, 6'd1, 120, 1, 32'd102);
    send_request(ACT_PACKET, 6'd1, 130, 1, 32'd10);
    send_request(ACT_PACKET, 6'd1, 140, 0, 32'd55);
    send_request(ACT_PACKET, 6'd2, 150, 0, 32'h5555_5555);
    send_request(ACT_PACKET, 6'd1, 70000, 1, 32'hAAAA_AAAA);
    send_request(ACT_TICK, 6'd0, 80000, 0, 0);
    send_request(ACT_TICK, 6'd0, 90000, 0, 0);
    send_request(ACT_PACKET, 6'd1, 85000, 1, 32'd7);
    send_request(ACT_PACKET, 6'd0, 95000, 0, 0);
    send_request(ACT_TICK, 6'd0, 10, 0, 0);
    drain();

    // Zero timeout and endless window
    write_reg(CFG_PERIOD, 22'd0);
    write_reg(CFG_WINDOW, 22'd0);
    send_request(ACT_PACKET, 6'd3, 1000, 1, 32'd5);
    send_request(ACT_TICK, 6'd0, 1001, 0, 0);
    send_request(ACT_PACKET, 6'd3, 900, 1, 32'd6);
    drain();

    // Random phases over several register settings and idle mixes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_PERIOD, 22'd1); write_reg(CFG_MULT, 22'd255);
                 write_reg(CFG_WINDOW, 22'd1000); end
        1: begin write_reg(CFG_PERIOD, 22'd3600000); write_reg(CFG_MULT, 22'd1);
                 write_reg(CFG_WINDOW, 22'd3600000); end
        2: begin write_reg(CFG_PERIOD, 22'd200); write_reg(CFG_MULT, 22'd2);
                 write_reg(CFG_WINDOW, 22'd0); end
        3: begin write_reg(CFG_PERIOD, 22'd100); write_reg(CFG_MULT, 22'd0);
                 write_reg(CFG_WINDOW, 22'd1); end
        default: begin write_reg(CFG_PERIOD, 22'd1000); write_reg(CFG_MULT, 22'd3);
                 write_reg(CFG_WINDOW, 22'd60000); end
      endcase
      case (ph)
        1: begin send_idle_pct = 47; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 47; end
        3: begin send_idle_pct = 11; recv_stall_pct = 11; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) hold_cycles = 3000;
      for (int k = 0; k < 50; k++) random_request();
      drain();
    end

    $display("covered %0d packet and %0d tick requests, %0d results checked",
             n_packets, n_ticks, sb.checked);
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (sb.pending.size() != 0) $display("%0d results never arrived", sb.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ flow_liveness_and_sequence_tracker.f @@
hdl/flt_pkg.sv
hdl/flt_rec_mem.sv
hdl/flt_win_div.sv
hdl/flow_liveness_and_sequence_tracker.sv
tb/flow_liveness_and_sequence_tracker_tb.sv
